/* hdl/nca_pkg.sv */
// Package for the nearest-center assignment block.
// Holds shared constants, the sequencer state type and the pipeline tag.
// No dependencies.
package nca_pkg;

    localparam int DIST_W    = 40;
    localparam int SQ_IN_W   = 20;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CI_W      = 4;
    localparam int DI_W      = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_W-1:0] NUM_CENTERS_RST = 5'd16;
    localparam logic [CFG_W-1:0] NUM_DIMS_RST    = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } nca_state_t;

    typedef struct packed {
        logic vld;
        logic last;
    } nca_tag_t;

endpackage

/* hdl/nca_sqdiff.sv */
// Shared squared-difference unit: two register stages, difference/magnitude
// then square with saturation. Depends on nca_pkg.
module nca_sqdiff #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nca_pkg::nca_tag_t        tag_in,
    input  logic [COORD_WIDTH-1:0]   a,
    input  logic [COORD_WIDTH-1:0]   b,
    output nca_pkg::nca_tag_t        tag_out,
    output logic [nca_pkg::DIST_W-1:0] sq
);
    import nca_pkg::*;

    localparam int MW  = COORD_WIDTH + 1;
    localparam int SQW = (MW > SQ_IN_W) ? SQ_IN_W : MW;

    logic signed [MW-1:0] diff;
    logic [MW-1:0]        mag;
    logic                 sat;
    logic [MW-1:0]        mag_reg;
    logic                 sat_reg;
    nca_tag_t             tag_a_reg;
    logic [2*SQW-1:0]     prod;
    logic [DIST_W-1:0]    sq_reg;
    logic [DIST_W-1:0]    sq_next;
    nca_tag_t             tag_b_reg;

    always_comb
    begin
        diff = signed'({a[COORD_WIDTH-1], a}) - signed'({b[COORD_WIDTH-1], b});
        mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
        sat  = |(mag >> SQ_IN_W);
        prod = mag_reg[SQW-1:0] * mag_reg[SQW-1:0];
        sq_next = sat_reg ? DIST_MAX : DIST_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag;
        sat_reg <= sat;
        sq_reg  <= sq_next;
    end

    assign tag_out = tag_b_reg;
    assign sq      = sq_reg;

endmodule

/* hdl/nearest_center_assign_core.sv */
// Top level of the nearest-center assignment block.
// Depends on nca_pkg and nca_sqdiff.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per center coordinate
//   load (mode 0) or per query point coordinate (mode 1). Output channel
//   (out_valid/out_ready) carries the nearest center index and its saturated
//   squared distance after the final query coordinate.
//   A load word is written straight into the center store. A query word walks
//   all MAX_CENTERS centers through one shared subtract/square unit, one center
//   per cycle, behind the center counter: one memory read, two unit stages and
//   one accumulate stage. A final coordinate then passes through a hold state
//   that hands the result to the output register.
//   in_ready is low while a query word is in flight.
//   Query words with coord_index at or beyond num_dims, clamped to 1..MAX_DIMS,
//   are dropped. The output register holds its word while out_ready is low;
//   input words are still taken, a final query's result waits for the slot.
//   Reset clears the running distances and sets both registers to 16; the
//   center store is not cleared and holds garbage until written.
//   Configuration writes (cfg_we) take effect at once, no handshake.
module nearest_center_assign_core #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nca_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [nca_pkg::CI_W-1:0]      center_index,
    input  logic [nca_pkg::DI_W-1:0]      coord_index,
    input  logic [COORD_WIDTH-1:0]        coord_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nca_pkg::CI_W-1:0]      nearest_center,
    output logic [nca_pkg::DIST_W-1:0]    min_distance
);
    import nca_pkg::*;

    localparam int DEPTH = MAX_CENTERS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);
    localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

    nca_state_t state_reg, state_next;

    logic [CFG_W-1:0]       num_centers_reg;
    logic [CFG_W-1:0]       num_dims_reg;

    logic [COORD_WIDTH-1:0] mem [DEPTH];
    logic [COORD_WIDTH-1:0] rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;

    logic [COORD_WIDTH-1:0] x_reg;
    logic [DI_W-1:0]        di_reg;
    logic                   first_reg;
    logic                   final_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [CNT_W-1:0]       k_eff;
    logic [31:0]            nd_eff;

    logic [CNT_W-1:0]       rj_reg, rj_next;
    logic [CNT_W-1:0]       wj_reg, wj_next;
    logic                   issue;
    nca_tag_t               rd_tag_reg;
    nca_tag_t               rd_tag_next;
    nca_tag_t               sq_tag;
    logic [DIST_W-1:0]      sq;

    logic [DIST_W-1:0]      partial [MAX_CENTERS];
    logic [IDX_W-1:0]       widx;
    logic [DIST_W:0]        acc_sum;
    logic [DIST_W-1:0]      acc;
    logic                   better;
    logic                   last_done;
    logic                   slot_free;

    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]      best_d_reg, best_d_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CI_W-1:0]        out_idx_reg;
    logic [DIST_W-1:0]      out_d_reg;
    logic                   out_load;

    logic                   in_acc;
    logic                   q_start;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (num_dims_reg == '0)
            nd_eff = 32'd1;
        else if (32'(num_dims_reg) > 32'(MAX_DIMS))
            nd_eff = 32'(MAX_DIMS);
        else
            nd_eff = 32'(num_dims_reg);

        if (num_centers_reg == '0)
            k_eff = CNT_W'(1);
        else if (32'(num_centers_reg) > 32'(MAX_CENTERS))
            k_eff = CNT_W'(MAX_CENTERS);
        else
            k_eff = CNT_W'(num_centers_reg);
    end

    assign q_start = in_acc && (mode == MODE_QUERY) && (32'(coord_index) < nd_eff);
    assign mem_we  = in_acc && (mode == MODE_LOAD)
                     && (32'(center_index) < 32'(MAX_CENTERS))
                     && (32'(coord_index) < 32'(MAX_DIMS));
    assign waddr   = AW'(32'(center_index) * 32'(MAX_DIMS) + 32'(coord_index));
    assign raddr   = AW'(32'(rj_reg) * 32'(MAX_DIMS) + 32'(di_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centers_reg <= NUM_CENTERS_RST;
            num_dims_reg    <= NUM_DIMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_CENTERS: num_centers_reg <= cfg_wdata;
                REG_NUM_DIMS:    num_dims_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // center store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= coord_value;
        rdata_reg <= mem[raddr];
    end

    // query context
    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            x_reg     <= coord_value;
            di_reg    <= coord_index;
            first_reg <= (coord_index == '0);
            final_reg <= (32'(coord_index) == nd_eff - 32'd1);
            k_reg     <= k_eff;
        end
    end

    // center sequencer and pipeline
    always_comb
    begin
        issue           = (state_reg == ST_RUN) && (rj_reg != CNT_W'(MAX_CENTERS));
        rd_tag_next.vld = issue;
        rd_tag_next.last = (rj_reg == CNT_W'(MAX_CENTERS - 1));
        rj_next = rj_reg;
        wj_next = wj_reg;
        if (q_start)
        begin
            rj_next = '0;
            wj_next = '0;
        end
        else
        begin
            if (issue)
                rj_next = rj_reg + CNT_W'(1);
            if (sq_tag.vld)
                wj_next = wj_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rj_reg     <= '0;
            wj_reg     <= '0;
            rd_tag_reg <= '0;
        end
        else
        begin
            rj_reg     <= rj_next;
            wj_reg     <= wj_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    nca_sqdiff #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqdiff (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .a       (x_reg),
        .b       (rdata_reg),
        .tag_out (sq_tag),
        .sq      (sq)
    );

    // accumulate and track the running minimum
    always_comb
    begin
        widx    = wj_reg[IDX_W-1:0];
        acc_sum = {1'b0, partial[widx]} + {1'b0, sq};
        if (first_reg)
            acc = sq;
        else if (acc_sum[DIST_W])
            acc = DIST_MAX;
        else
            acc = acc_sum[DIST_W-1:0];
        better = (wj_reg == '0) || ((wj_reg < k_reg) && (acc <= best_d_reg));
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        if (sq_tag.vld && better)
        begin
            best_idx_next = widx;
            best_d_next   = acc;
        end
        last_done = sq_tag.vld && sq_tag.last;
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CENTERS; i++)
                partial[i] <= '0;
        end
        else if (last_done && final_reg)
        begin
            for (int i = 0; i < MAX_CENTERS; i++)
                partial[i] <= '0;
        end
        else if (sq_tag.vld)
        begin
            partial[widx] <= acc;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (last_done)
                    state_next = final_reg ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg <= CI_W'(best_idx_reg);
            out_d_reg   <= best_d_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign nearest_center = out_idx_reg;
    assign min_distance   = out_d_reg;

    // checks
    a_drain_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        sq_tag.vld |-> (state_reg == ST_RUN))
        else $error("unit output outside of a query pass");

    a_hold_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> (final_reg && (partial[0] == '0)))
        else $error("result pending without final coordinate or uncleared sums");

    a_hold_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && slot_free) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("result not handed to output register");

endmodule

/* bench/nca_checker.sv */
`timescale 1ns / 1ps
// Checker for nearest_center_assign_core: tracks register writes, predicts each assignment
// from the accepted input words and compares it with the output channel.
// Depends on nca_pkg.
module nca_checker #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nca_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          mode,
    input  logic [nca_pkg::CI_W-1:0]      center_index,
    input  logic [nca_pkg::DI_W-1:0]      coord_index,
    input  logic [COORD_WIDTH-1:0]        coord_value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [nca_pkg::CI_W-1:0]      nearest_center,
    input  logic [nca_pkg::DIST_W-1:0]    min_distance,
    output int                            mismatch_count,
    output int                            pending_count,
    output int                            result_count
);
    import nca_pkg::*;

    typedef struct packed {
        logic [CI_W-1:0]   center;
        logic [DIST_W-1:0] distance;
    } assignment_t;

    logic [COORD_WIDTH-1:0] center_mem [MAX_CENTERS*MAX_DIMS];
    logic [DIST_W-1:0]      run_dist [MAX_CENTERS];
    logic [CFG_W-1:0]       cfg_centers;
    logic [CFG_W-1:0]       cfg_dims;
    assignment_t            assign_q [$];

    initial
    begin
        for (int i = 0; i < MAX_CENTERS*MAX_DIMS; i++)
            center_mem[i] = '0;
    end

    function automatic int clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic logic [DIST_W-1:0] sq_diff(input logic signed [COORD_WIDTH-1:0] a,
                                                 input logic signed [COORD_WIDTH-1:0] b);
        longint          d;
        longint unsigned mag;
        longint unsigned sq;
        d   = longint'(a) - longint'(b);
        mag = (d < 0) ? longint'(-d) : longint'(d);
        if (mag >= (64'd1 << SQ_IN_W))
            return DIST_MAX;
        sq = mag * mag;
        return sq[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    task automatic take_word(input logic m, input logic [CI_W-1:0] ci,
                             input logic [DI_W-1:0] di, input logic [COORD_WIDTH-1:0] val);
        int                k;
        int                nd;
        int                best;
        logic [DIST_W-1:0] bestd;
        logic [DIST_W-1:0] s;
        assignment_t       r;
        k  = clamp_cfg(cfg_centers, MAX_CENTERS);
        nd = clamp_cfg(cfg_dims, MAX_DIMS);
        if (m == MODE_LOAD)
        begin
            if (ci < MAX_CENTERS && di < MAX_DIMS)
                center_mem[ci*MAX_DIMS + di] = val;
            return;
        end
        if (di >= nd)
            return;
        for (int j = 0; j < MAX_CENTERS; j++)
        begin
            s = sq_diff(val, center_mem[j*MAX_DIMS + di]);
            run_dist[j] = (di == 0) ? s : add_sat(run_dist[j], s);
        end
        if (di != nd - 1)
            return;
        best  = 0;
        bestd = run_dist[0];
        for (int j = 1; j < k; j++)
        begin
            if (run_dist[j] <= bestd)
            begin
                best  = j;
                bestd = run_dist[j];
            end
        end
        for (int j = 0; j < MAX_CENTERS; j++)
            run_dist[j] = '0;
        r.center   = best[CI_W-1:0];
        r.distance = bestd;
        assign_q   = {assign_q, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        assignment_t exp_r;
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_CENTERS; j++)
                run_dist[j] = '0;
            cfg_centers    = NUM_CENTERS_RST;
            cfg_dims       = NUM_DIMS_RST;
            assign_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
            result_count   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (assign_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: center %0d distance %0d",
                                 nearest_center, min_distance);
                end
                else
                begin
                    exp_r = assign_q.pop_front();
                    if (nearest_center !== exp_r.center || min_distance !== exp_r.distance)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected center %0d distance %0d, ",
                                      "got center %0d distance %0d"},
                                     result_count, exp_r.center, exp_r.distance,
                                     nearest_center, min_distance);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_NUM_CENTERS)
                    cfg_centers = cfg_wdata;
                else if (cfg_index == REG_NUM_DIMS)
                    cfg_dims = cfg_wdata;
            end
            if (in_valid && in_ready)
                take_word(mode, center_index, coord_index, coord_value);
            pending_count = assign_q.size();
        end
    end

endmodule

/* bench/tb_nearest_center_assign_core.sv */
`timescale 1ns / 1ps
// Top of the nearest_center_assign_core regression: clock, reset, register writes and
// randomized load/query words with random idling; verdict from nca_checker.
// Depends on nca_pkg, nca_checker and the block under test.
module tb_nearest_center_assign_core;
    import nca_pkg::*;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam int WORD_TARGET = 1300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic                   mode;
    logic [CI_W-1:0]        center_index;
    logic [DI_W-1:0]        coord_index;
    logic [COORD_WIDTH-1:0] coord_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [CI_W-1:0]        nearest_center;
    logic [DIST_W-1:0]      min_distance;

    int mismatch_count;
    int pending_count;
    int result_count;
    int words_sent;
    int dropped_words;
    int settings_used;
    int cur_dims;
    bit steady;

    logic [COORD_WIDTH-1:0] mirror [NUM_SLOTS][NUM_SLOTS];

    nearest_center_assign_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .center_index   (center_index),
        .coord_index    (coord_index),
        .coord_value    (coord_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .nearest_center (nearest_center),
        .min_distance   (min_distance)
    );

    nca_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .center_index   (center_index),
        .coord_index    (coord_index),
        .coord_value    (coord_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .nearest_center (nearest_center),
        .min_distance   (min_distance),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("nearest_center_assign_core regression: fail");
        $finish;
    end

    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic int clamp_cfg(input int v);
        if (v < 1)
            return 1;
        if (v > NUM_SLOTS)
            return NUM_SLOTS;
        return v;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_value(input int di);
        int                     r;
        int                     c;
        logic [COORD_WIDTH-1:0] v;
        r = $urandom_range(0, 9);
        c = $urandom_range(0, NUM_SLOTS - 1);
        v = COORD_WIDTH'($urandom);
        if (r < 5)
            return v;
        if (r < 7)
            return mirror[c][di];
        if (r < 9)
            return COORD_WIDTH'(mirror[c][di] + $urandom_range(0, 64) - 32);
        return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input bit favor_small);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return CFG_W'($urandom_range(17, 31));
            default: return favor_small ? CFG_W'($urandom_range(1, 5))
                                        : CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic send_word(input logic m, input logic [CI_W-1:0] ci,
                             input logic [DI_W-1:0] di, input logic [COORD_WIDTH-1:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        center_index <= ci;
        coord_index  <= di;
        coord_value  <= val;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (m == MODE_LOAD)
            mirror[ci][di] = val;
        words_sent++;
    endtask

    task automatic send_coord(input int di);
        send_word(MODE_QUERY, CI_W'($urandom), DI_W'(di), pick_value(di));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] nc, input logic [CFG_W-1:0] nd);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUM_CENTERS;
        cfg_wdata <= nc;
        @(negedge clk);
        cfg_index <= REG_NUM_DIMS;
        cfg_wdata <= nd;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_dims = clamp_cfg(int'(nd));
        settings_used++;
    endtask

    initial
    begin : stimulus
        int act;
        int n;
        int c;
        int d;
        logic [COORD_WIDTH-1:0] v;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        center_index  = '0;
        coord_index   = '0;
        coord_value   = '0;
        steady        = 1'b0;
        words_sent    = 0;
        dropped_words = 0;
        settings_used = 0;
        cur_dims      = NUM_SLOTS;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the whole center store: two extreme centers, a zero one, a duplicate pair
        for (c = 0; c < NUM_SLOTS; c++)
        begin
            for (d = 0; d < NUM_SLOTS; d++)
            begin
                v = COORD_WIDTH'($urandom);
                if (c == 0)
                    v = 16'h8000;
                else if (c == 1)
                    v = 16'h7FFF;
                else if (c == 2)
                    v = '0;
                else if (c == 9)
                    v = mirror[5][d];
                send_word(MODE_LOAD, CI_W'(c), DI_W'(d), v);
            end
        end

        settle();
        write_config(5'd16, 5'd1);
        send_word(MODE_QUERY, 4'hF, 4'd0, 16'h7FFF);
        send_word(MODE_QUERY, 4'h0, 4'd0, 16'h8000);
        send_word(MODE_QUERY, 4'h3, 4'd0, mirror[5][0]);

        settle();
        write_config(5'd0, 5'd0);
        send_word(MODE_QUERY, 4'h0, 4'd0, 16'h7FFF);

        settle();
        write_config(5'd31, 5'd3);
        send_coord(0);
        send_coord(1);
        send_coord(0);
        send_coord(2);
        send_coord(1);
        send_coord(0);
        send_coord(2);
        send_word(MODE_QUERY, 4'h0, 4'd5, 16'h1234);
        send_word(MODE_QUERY, 4'hF, 4'd15, 16'hFFFF);
        dropped_words += 2;
        send_coord(0);
        send_word(MODE_LOAD, 4'd4, 4'd1, 16'h4000);
        send_coord(1);
        send_coord(2);

        while (words_sent - dropped_words < WORD_TARGET)
        begin
            settle();
            write_config(pick_reg(1'b0), pick_reg(1'b1));
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(8, 20))
            begin
                act = $urandom_range(0, 9);
                if (act == 9 && cur_dims < NUM_SLOTS)
                begin
                    send_word(MODE_QUERY, CI_W'($urandom),
                              DI_W'($urandom_range(cur_dims, NUM_SLOTS - 1)),
                              COORD_WIDTH'($urandom));
                    dropped_words++;
                end
                else if (act == 6)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        c = $urandom_range(0, NUM_SLOTS - 1);
                        d = $urandom_range(0, NUM_SLOTS - 1);
                        v = ($urandom_range(0, 1) == 1)
                            ? mirror[$urandom_range(0, NUM_SLOTS - 1)][d]
                            : COORD_WIDTH'($urandom);
                        send_word(MODE_LOAD, CI_W'(c), DI_W'(d), v);
                    end
                end
                else if (act == 7 && cur_dims > 1)
                begin
                    n = $urandom_range(1, cur_dims - 1);
                    for (d = 0; d < n; d++)
                        send_coord(d);
                end
                else if (act == 8)
                begin
                    repeat ($urandom_range(1, 4))
                        send_coord($urandom_range(0, cur_dims - 1));
                    send_coord(cur_dims - 1);
                end
                else
                begin
                    for (d = 0; d < cur_dims; d++)
                        send_coord(d);
                end
            end
        end

        steady = 1'b0;
        settle();
        $display("run covered %0d input words (%0d dropped by design) over %0d register settings",
                 words_sent, dropped_words, settings_used);
        $display("%0d nearest-center results compared, %0d mismatches",
                 result_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("nearest_center_assign_core regression: pass");
        else
            $display("nearest_center_assign_core regression: fail");
        $finish;
    end

endmodule
